// ===== rtl/psoa_pkg.sv =====
// Shared constants and types for the product scanning operand addresser.
// Used by psoa_col_setup, psoa_pair_unit and product_scan_operand_addresser.
`timescale 1ns / 1ps
`default_nettype none

package psoa_pkg;

  localparam int unsigned MAX_LIMBS = 32;
  // Largest usable limb count: MAX_LIMBS, but never above what a 5-bit index reaches
  localparam int unsigned LIMB_CAP  = (MAX_LIMBS < 32) ? MAX_LIMBS : 32;

  localparam int unsigned LIMB_W  = 6;  // limb count register width
  localparam int unsigned INDEX_W = 5;  // limb index width
  localparam int unsigned COL_W   = 6;  // column index width
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_LIMBS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_LIMBS = 2'd1;

  // Column description handed from setup to the pair unit
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [INDEX_W-1:0] a_hi;
    logic [INDEX_W-1:0] a_lo;
    logic               last_col;
  } col_t;

  // One index pair as presented at the output
  typedef struct packed {
    logic [INDEX_W-1:0] a_idx;
    logic [INDEX_W-1:0] b_idx;
    logic [COL_W-1:0]   col;
    logic               last_in_col;
    logic               last_col;
  } pair_t;

  // Clamp a limb count register to 1 .. LIMB_CAP
  function automatic logic [LIMB_W-1:0] eff_limbs(input logic [LIMB_W-1:0] v);
    logic [LIMB_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LIMB_W'(1);
    end else if (v > LIMB_W'(LIMB_CAP)) begin
      r = LIMB_W'(LIMB_CAP);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/product_scan_operand_addresser.sv =====
// Product scanning operand addresser: emits the limb index pairs of one column per request.
// Each accepted request loads the pair unit; each pair is then registered into the output when the slot is free.
// Throughput: one pair per cycle from the pair stepping unit while the output is not stalled;
// a column of n pairs (n up to 32) holds off the next request until its last pair leaves the unit.
// Reset: limb counts return to 1, the product restarts at column 0, output empties.
// Depends on psoa_pkg, psoa_col_setup and psoa_pair_unit.
`timescale 1ns / 1ps
`default_nettype none

module product_scan_operand_addresser import psoa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LIMB_W-1:0]    cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 restart_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [INDEX_W-1:0]        a_index_o,
  output logic [INDEX_W-1:0]        b_index_o,
  output logic [COL_W-1:0]          column_o,
  output logic                      last_in_column_o,
  output logic                      last_column_o
);

  col_t  col;
  pair_t pair;
  pair_t out_q;
  logic  busy;
  logic  take;
  logic  slot_free;
  logic  advance;
  logic  ovld_q, ovld_d;

  assign in_stall_o = busy;
  assign take       = in_valid_i && !busy;
  assign slot_free  = !ovld_q || !out_stall_i;
  assign advance    = busy && slot_free;

  psoa_col_setup u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .take_i     (take),
    .restart_i  (restart_i),
    .col_o      (col)
  );

  psoa_pair_unit u_pair (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .col_i    (col),
    .advance_i(advance),
    .busy_o   (busy),
    .pair_o   (pair)
  );

  always_comb begin
    ovld_d = ovld_q;
    if (advance) begin
      ovld_d = 1'b1;
    end else if (!out_stall_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= pair;
    end
  end

  assign out_valid_o      = ovld_q;
  assign a_index_o        = out_q.a_idx;
  assign b_index_o        = out_q.b_idx;
  assign column_o         = out_q.col;
  assign last_in_column_o = out_q.last_in_col;
  assign last_column_o    = out_q.last_col;

  // An accepted request keeps the unit busy for at least one pair
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> busy)
    else $error("request accepted but pair unit idle");

  // Each pair sums to its column
  a_col_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (column_o == (COL_W'(a_index_o) + COL_W'(b_index_o))))
    else $error("column differs from index sum");

  // The unit only goes idle right after loading the column's last pair
  a_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (out_valid_o && last_in_column_o))
    else $error("column ended without last pair flag");

  // A pair is never overwritten while the consumer stalls
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !advance)
    else $error("output overwritten under stall");

endmodule

`default_nettype wire

// ===== rtl/psoa_col_setup.sv =====
// Configuration registers, column counter and per-column bounds.
// Depends on psoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psoa_col_setup import psoa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LIMB_W-1:0]    cfg_wdata_i,
  input  wire logic                 take_i,
  input  wire logic                 restart_i,
  output col_t                      col_o
);

  logic [LIMB_W-1:0] a_limbs_q, a_limbs_d;
  logic [LIMB_W-1:0] b_limbs_q, b_limbs_d;
  logic [COL_W-1:0]  next_col_q, next_col_d;

  logic [LIMB_W-1:0]  na, nb;
  logic [INDEX_W-1:0] na_m1, nb_m1;
  logic [COL_W-1:0]   final_col;
  logic [COL_W-1:0]   c;
  logic [COL_W-1:0]   a_lo_wide;

  always_comb begin
    a_limbs_d = a_limbs_q;
    b_limbs_d = b_limbs_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_A_LIMBS: a_limbs_d = cfg_wdata_i;
        CFG_B_LIMBS: b_limbs_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    na        = eff_limbs(a_limbs_q);
    nb        = eff_limbs(b_limbs_q);
    na_m1     = INDEX_W'(na - LIMB_W'(1));
    nb_m1     = INDEX_W'(nb - LIMB_W'(1));
    final_col = COL_W'(na_m1) + COL_W'(nb_m1);
    // Restart, or a stale counter after a register change, goes back to column 0
    c = (restart_i || (next_col_q > final_col)) ? '0 : next_col_q;
    a_lo_wide = (c > COL_W'(nb_m1)) ? (c - COL_W'(nb_m1)) : '0;

    col_o.col      = c;
    col_o.a_hi     = (c < COL_W'(na_m1)) ? INDEX_W'(c) : na_m1;
    col_o.a_lo     = INDEX_W'(a_lo_wide);
    col_o.last_col = (c == final_col);

    next_col_d = next_col_q;
    if (take_i) begin
      next_col_d = col_o.last_col ? '0 : (c + COL_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_limbs_q  <= LIMB_W'(1);
      b_limbs_q  <= LIMB_W'(1);
      next_col_q <= '0;
    end else begin
      a_limbs_q  <= a_limbs_d;
      b_limbs_q  <= b_limbs_d;
      next_col_q <= next_col_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/psoa_pair_unit.sv =====
// Pair stepping unit: one shared decrement and compare walks the A index
// from the column's top bound down to its bottom bound. Depends on psoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psoa_pair_unit import psoa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire col_t col_i,
  input  wire logic advance_i,
  output logic      busy_o,
  output pair_t     pair_o
);

  logic               busy_q, busy_d;
  logic [INDEX_W-1:0] a_q, a_d;
  logic [INDEX_W-1:0] a_lo_q, a_lo_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               last_col_q, last_col_d;
  logic               at_end;
  logic [COL_W-1:0]   b_wide;

  assign at_end = (a_q == a_lo_q);
  assign b_wide = col_q - COL_W'(a_q);

  always_comb begin
    busy_d     = busy_q;
    a_d        = a_q;
    a_lo_d     = a_lo_q;
    col_d      = col_q;
    last_col_d = last_col_q;
    if (load_i) begin
      busy_d     = 1'b1;
      a_d        = col_i.a_hi;
      a_lo_d     = col_i.a_lo;
      col_d      = col_i.col;
      last_col_d = col_i.last_col;
    end else if (advance_i && busy_q) begin
      // Drop out after the bottom pair, otherwise step A down
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        a_d = a_q - INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    a_lo_q     <= a_lo_d;
    col_q      <= col_d;
    last_col_q <= last_col_d;
  end

  assign busy_o             = busy_q;
  assign pair_o.a_idx       = a_q;
  assign pair_o.b_idx       = INDEX_W'(b_wide);
  assign pair_o.col         = col_q;
  assign pair_o.last_in_col = at_end;
  assign pair_o.last_col    = last_col_q;

endmodule

`default_nettype wire

// ===== test/product_scan_operand_addresser_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for product_scan_operand_addresser: drives column requests,
// predicts every limb index pair of each column and compares the pair stream.
// Depends on psoa_pkg and the product_scan_operand_addresser RTL.

module product_scan_operand_addresser_test;
  import psoa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // decodes to no register
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_PRINTED = 200;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [LIMB_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 restart_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [INDEX_W-1:0]   a_index_o;
  logic [INDEX_W-1:0]   b_index_o;
  logic [COL_W-1:0]     column_o;
  logic                 last_in_column_o;
  logic                 last_column_o;

  product_scan_operand_addresser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .a_index_o        (a_index_o),
    .b_index_o        (b_index_o),
    .column_o         (column_o),
    .last_in_column_o (last_in_column_o),
    .last_column_o    (last_column_o)
  );

  logic        request_queue[$];  // restart flag of each column request not yet taken
  pair_t       pair_queue[$];     // index pairs still owed by the block
  pair_t       pair_want;

  logic [LIMB_W-1:0] a_limbs_reg = LIMB_W'(1);
  logic [LIMB_W-1:0] b_limbs_reg = LIMB_W'(1);
  int unsigned       column_next = 0;

  int unsigned send_idle_pct = 12;
  int unsigned stall_pct = 45;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic        request_taken = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned usable_limbs(input logic [LIMB_W-1:0] v);
    int unsigned n;
    n = v;
    if (n == 0) begin
      n = 1;
    end else if (n > LIMB_CAP) begin
      n = LIMB_CAP;
    end
    return n;
  endfunction

  // Queue every pair of the column that one request issues and advance the column.
  function automatic void issue_column(input logic restart);
    int unsigned na, nb, final_col, c, a_hi, a_lo;
    int          a;
    pair_t       p;
    na = usable_limbs(a_limbs_reg);
    nb = usable_limbs(b_limbs_reg);
    final_col = na + nb - 2;
    c = column_next;
    // a column left over from larger limb counts falls back to column 0
    if (restart || c > final_col) c = 0;
    a_hi = (c < na - 1) ? c : na - 1;
    a_lo = (c > nb - 1) ? c - (nb - 1) : 0;
    for (a = int'(a_hi); a >= int'(a_lo); a--) begin
      p.a_idx       = INDEX_W'(a);
      p.b_idx       = INDEX_W'(int'(c) - a);
      p.col         = COL_W'(c);
      p.last_in_col = (a == int'(a_lo));
      p.last_col    = (c == final_col);
      pair_queue.push_back(p);
    end
    column_next = (c == final_col) ? 0 : c + 1;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic write_limbs(input logic [CFG_IDX_W-1:0] idx, input logic [LIMB_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    if (idx == CFG_A_LIMBS) begin
      a_limbs_reg = value;
    end else if (idx == CFG_B_LIMBS) begin
      b_limbs_reg = value;
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Hold until every request is taken and every pair has arrived, then let the block go quiet.
  task automatic settle();
    while (request_queue.size() != 0 || pair_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [LIMB_W-1:0] pick_limbs();
    int unsigned r;
    r = $urandom_range(11);
    if (r == 0) return '0;
    if (r == 1) return LIMB_W'($urandom_range(63, 33));
    if (r == 2) return LIMB_W'(32);
    return LIMB_W'($urandom_range(31, 1));
  endfunction

  // Driver: hold a request until it is taken, then present the next one or idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || request_taken) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        restart_i <= request_queue[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    request_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      issue_column(restart_i);
      void'(request_queue.pop_front());
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pair_queue.size() == 0) begin
        report_error($sformatf("unexpected pair a=%0d b=%0d column=%0d",
                               a_index_o, b_index_o, column_o));
      end else begin
        pair_want = pair_queue.pop_front();
        check_field("a_index", a_index_o, pair_want.a_idx);
        check_field("b_index", b_index_o, pair_want.b_idx);
        check_field("column", column_o, pair_want.col);
        check_field("last_in_column", last_in_column_o, pair_want.last_in_col);
        check_field("last_column", last_column_o, pair_want.last_col);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned n_requests;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset limb counts: every column is column 0 and the final one
    request_queue.push_back(1'b0);
    request_queue.push_back(1'b1);
    request_queue.push_back(1'b0);
    settle();

    // full 3 x 5 product through all three phases, then wrap to column 0
    write_limbs(CFG_A_LIMBS, LIMB_W'(3));
    write_limbs(CFG_B_LIMBS, LIMB_W'(5));
    repeat (8) request_queue.push_back(1'b0);
    settle();

    // shrink mid product: the pending column now lies past the end; zero acts as one
    write_limbs(CFG_A_LIMBS, '0);
    write_limbs(CFG_B_LIMBS, LIMB_W'(1));
    repeat (2) request_queue.push_back(1'b0);
    settle();

    // oversized A clamps to the cap; a write to the spare index changes nothing
    write_limbs(CFG_A_LIMBS, '1);
    write_limbs(CFG_B_LIMBS, '0);
    write_limbs(CFG_SPARE, '1);
    request_queue.push_back(1'b1);
    repeat (3) request_queue.push_back(1'b0);
    settle();

    write_limbs(CFG_A_LIMBS, LIMB_W'(2));
    write_limbs(CFG_B_LIMBS, LIMB_W'(33));
    request_queue.push_back(1'b1);
    repeat (3) request_queue.push_back(1'b0);
    settle();

    for (phase_no = 0; phase_no < 8; phase_no++) begin
      if (phase_no == 3) begin
        send_idle_pct = 45;
        stall_pct = 12;
      end else if (phase_no == 6) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      if (phase_no == 4) begin
        // largest product, run through once and into the next one
        write_limbs(CFG_A_LIMBS, LIMB_W'(32));
        write_limbs(CFG_B_LIMBS, LIMB_W'(32));
        n_requests = 66;
      end else begin
        write_limbs(CFG_A_LIMBS, pick_limbs());
        write_limbs(CFG_B_LIMBS, pick_limbs());
        n_requests = $urandom_range(24, 8);
      end
      repeat (n_requests) request_queue.push_back($urandom_range(19) == 0);
      settle();
    end

    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
